[hw/rtl/tzps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tzps_pkg
// shared types and constants of the triangle z-plane slice unit
// ----------------------------------------------------------------------------
package tzps_pkg;

  localparam int CW = 32;  // coordinate width
  localparam int FB = 16;  // fractional bits of the edge fraction
  localparam int IN_W = 10 * CW;
  localparam int OUT_W = 32 + 6 * CW;
  localparam int AW = 3;   // apb address width
  localparam int DIV_STEPS = FB;
  localparam int NSTG = DIV_STEPS + 4;  // front, rotate, divider, multiply, output

  localparam logic [AW-1:0] ADDR_Z_LEVEL = AW'(0);

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [CW-1:0] mag_t;

  typedef struct packed {
    logic [31:0]          face;
    coord_t [2:0][2:0]    pos;   // [vertex][axis]
    mag_t [2:0]           mag;
    logic [2:0]           below;
  } front_t;

  typedef struct packed {
    logic [31:0]     face;
    logic            crossed;
    coord_t [2:0]    pa;     // near vertex of edge a
    coord_t [2:0]    pb;     // near vertex of edge b
    mag_t [2:0]      ma;     // |mid - near|, later the offset
    mag_t [2:0]      mb;
    logic [2:0]      na;     // mid below near per axis
    logic [2:0]      nb;
    logic [CW:0]     sa;     // divisor
    logic [CW:0]     sb;
    logic [CW:0]     ra;     // partial remainder
    logic [CW:0]     rb;
    logic [FB-1:0]   qa;
    logic [FB-1:0]   qb;
    logic            onea;   // fraction is exactly one
    logic            oneb;
  } pipe_t;

endpackage

[hw/rtl/triangle_z_plane_slice_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_z_plane_slice_unit
// slices one triangle per cycle, unless m_axis stalls, against a horizontal plane z = z_level
// ----------------------------------------------------------------------------
// usage
//   s_axis: one word per triangle, tdata holds face_index then v0_x .. v2_z
//   m_axis: one word per triangle, tdata holds face_out and the segment ends,
//           tuser holds crossed; a triangle the plane misses gives zero segment ends
//   apb: z_level at byte address 0, write it only while the block is empty
// pipeline and throughput
//   20 register stages: a front stage (distances), a rotate stage, 16
//   restoring divider stages (one fraction bit each), a multiply stage and
//   the output register, which drives m_axis
//   one triangle per cycle sustained while m_axis is not stalled;
//   the divider chain sets the depth
// reset
//   all stage valid bits clear, z_level returns to zero
// stall
//   each stage has its own valid bit and moves when the stage after it has
//   room, so bubbles close up and s_axis stays ready until every stage holds
//   a word and m_axis is stalled; nothing is dropped or repeated
// ----------------------------------------------------------------------------
module triangle_z_plane_slice_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // face_index, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
  input  logic [tzps_pkg::IN_W-1:0]  s_axis_tdata_i,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // face_out, a_x, a_y, a_z, b_x, b_y, b_z
  output logic [tzps_pkg::OUT_W-1:0] m_axis_tdata_o,
  // crossed
  output logic                       m_axis_tuser_o,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic [tzps_pkg::AW-1:0]    paddr_i,
  input  logic [31:0]                pwdata_i,
  output logic [31:0]                prdata_o,
  output logic                       pready_o
);
  import tzps_pkg::*;

  localparam logic [CW:0] NEG_CAP = (CW+1)'(1) << (CW - 1);

  coord_t z_level_q;
  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] en;

  front_t front_d, front_q;
  pipe_t  rot_d;
  pipe_t  div_q [DIV_STEPS+1];
  pipe_t  mul_d, mul_q;
  logic [OUT_W-1:0] out_data_d, out_data_q;
  logic out_cross_q;

  // ---------------------------------------------------------------- config
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i == ADDR_Z_LEVEL) ? z_level_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z_level_q <= '0;
    end else if (psel_i && penable_i && pwrite_i && paddr_i == ADDR_Z_LEVEL) begin
      z_level_q <= pwdata_i;
    end
  end

  // ------------------------------------------------------------- flow ctrl
  // a stage loads when it is empty or its word moves on
  always_comb begin
    en[NSTG-1] = !vld_q[NSTG-1] || m_axis_tready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign s_axis_tready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= s_axis_tvalid_i;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // ------------------------------------------------- stage 0: distances
  always_comb begin
    logic signed [CW:0] d;
    logic [CW:0] nm;
    front_d.face = s_axis_tdata_i[31:0];
    for (int v = 0; v < 3; v++) begin
      for (int a = 0; a < 3; a++) begin
        front_d.pos[v][a] = s_axis_tdata_i[32 + (3*v + a)*CW +: CW];
      end
      d = {front_d.pos[v][2][CW-1], front_d.pos[v][2]} - {z_level_q[CW-1], z_level_q};
      front_d.below[v] = d[CW];
      nm = -d;
      if (d[CW]) begin
        // saturate at the magnitude of the most negative value
        front_d.mag[v] = (nm > NEG_CAP) ? NEG_CAP[CW-1:0] : nm[CW-1:0];
      end else begin
        front_d.mag[v] = (d[CW-1]) ? {1'b0, {(CW-1){1'b1}}} : d[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) front_q <= front_d;
  end

  // ------------------------------------------- stage 1: rotate and set up
  always_comb begin
    logic [1:0] r0, r1, r2;
    logic signed [CW:0] da, db;
    logic [CW:0] na_ext, nb_ext;
    if (front_q.below[2] == front_q.below[0]) begin
      r0 = 2'd0; r1 = 2'd1; r2 = 2'd2;
    end else if (front_q.below[0] == front_q.below[1]) begin
      r0 = 2'd1; r1 = 2'd2; r2 = 2'd0;
    end else begin
      r0 = 2'd2; r1 = 2'd0; r2 = 2'd1;
    end
    rot_d = '0;
    rot_d.face = front_q.face;
    rot_d.crossed = (front_q.below != 3'b000) && (front_q.below != 3'b111);
    for (int a = 0; a < 3; a++) begin
      rot_d.pa[a] = front_q.pos[r0][a];
      rot_d.pb[a] = front_q.pos[r2][a];
      da = {front_q.pos[r1][a][CW-1], front_q.pos[r1][a]}
         - {front_q.pos[r0][a][CW-1], front_q.pos[r0][a]};
      db = {front_q.pos[r1][a][CW-1], front_q.pos[r1][a]}
         - {front_q.pos[r2][a][CW-1], front_q.pos[r2][a]};
      rot_d.na[a] = da[CW];
      rot_d.nb[a] = db[CW];
      na_ext = da[CW] ? -da : da;
      nb_ext = db[CW] ? -db : db;
      rot_d.ma[a] = na_ext[CW-1:0];
      rot_d.mb[a] = nb_ext[CW-1:0];
    end
    rot_d.sa = {1'b0, front_q.mag[r0]} + {1'b0, front_q.mag[r1]};
    rot_d.sb = {1'b0, front_q.mag[r2]} + {1'b0, front_q.mag[r1]};
    rot_d.ra = {1'b0, front_q.mag[r0]};
    rot_d.rb = {1'b0, front_q.mag[r2]};
    rot_d.onea = (front_q.mag[r1] == '0);
    rot_d.oneb = (front_q.mag[r1] == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) div_q[0] <= rot_d;
  end

  // ------------------------------------- stages 2..17: one quotient bit each
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    pipe_t step_d;

    always_comb begin
      logic [CW+1:0] sha, shb;
      step_d = div_q[g];
      sha = {div_q[g].ra, 1'b0};
      shb = {div_q[g].rb, 1'b0};
      if (sha >= {1'b0, div_q[g].sa}) begin
        sha = sha - {1'b0, div_q[g].sa};
        step_d.qa = {div_q[g].qa[FB-2:0], 1'b1};
      end else begin
        step_d.qa = {div_q[g].qa[FB-2:0], 1'b0};
      end
      if (shb >= {1'b0, div_q[g].sb}) begin
        shb = shb - {1'b0, div_q[g].sb};
        step_d.qb = {div_q[g].qb[FB-2:0], 1'b1};
      end else begin
        step_d.qb = {div_q[g].qb[FB-2:0], 1'b0};
      end
      step_d.ra = sha[CW:0];
      step_d.rb = shb[CW:0];
    end

    always_ff @(posedge clk_i) begin
      if (en[g+2]) div_q[g+1] <= step_d;
    end
  end

  // ------------------------------------ multiply stage: offsets along edges
  always_comb begin
    logic [FB:0] ta, tb;
    logic [FB+CW:0] pra, prb;
    ta = div_q[DIV_STEPS].onea ? (FB+1)'(1) << FB : {1'b0, div_q[DIV_STEPS].qa};
    tb = div_q[DIV_STEPS].oneb ? (FB+1)'(1) << FB : {1'b0, div_q[DIV_STEPS].qb};
    mul_d = div_q[DIV_STEPS];
    for (int a = 0; a < 3; a++) begin
      pra = (FB+CW+1)'(ta) * (FB+CW+1)'(div_q[DIV_STEPS].ma[a]);
      prb = (FB+CW+1)'(tb) * (FB+CW+1)'(div_q[DIV_STEPS].mb[a]);
      // offsets replace the edge lengths from here on
      mul_d.ma[a] = pra[FB +: CW];
      mul_d.mb[a] = prb[FB +: CW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NSTG-2]) mul_q <= mul_d;
  end

  // ------------------------------------------------- output stage
  always_comb begin
    coord_t ea, eb;
    out_data_d = '0;
    out_data_d[31:0] = mul_q.face;
    for (int a = 0; a < 3; a++) begin
      ea = mul_q.na[a] ? mul_q.pa[a] - coord_t'(mul_q.ma[a])
                       : mul_q.pa[a] + coord_t'(mul_q.ma[a]);
      eb = mul_q.nb[a] ? mul_q.pb[a] - coord_t'(mul_q.mb[a])
                       : mul_q.pb[a] + coord_t'(mul_q.mb[a]);
      if (mul_q.crossed) begin
        out_data_d[32 + a*CW +: CW] = ea;
        out_data_d[32 + (3+a)*CW +: CW] = eb;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NSTG-1]) begin
      out_data_q  <= out_data_d;
      out_cross_q <= mul_q.crossed;
    end
  end

  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_cross_q;
  assign m_axis_tvalid_o = vld_q[NSTG-1];

`ifndef ASSERT_OFF
  // input is only held off when the pipe is full and the output is stalled
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i && (&vld_q)))
    else $error("input stalled with room in the pipe");

  // a missed triangle carries a zero segment
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o[OUT_W-1:32] == '0))
    else $error("segment not cleared for missed triangle");

  // an accepted word lands in the front stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> vld_q[0])
    else $error("accepted word lost at front stage");
`endif

endmodule

[dv/triangle_z_plane_slice_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_z_plane_slice_checker
// watches the triangle and segment streams and the apb writes, predicts each
// segment word from the accepted triangle and compares field by field
// ----------------------------------------------------------------------------
module triangle_z_plane_slice_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [tzps_pkg::IN_W-1:0]  s_tdata_i,
  input  logic                       s_tvalid_i,
  input  logic                       s_tready_i,
  input  logic [tzps_pkg::OUT_W-1:0] m_tdata_i,
  input  logic                       m_tuser_i,
  input  logic                       m_tvalid_i,
  input  logic                       m_tready_i,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic [tzps_pkg::AW-1:0]    paddr_i,
  input  logic [31:0]                pwdata_i,
  input  logic                       pready_i,
  output int                         fail_count_o,
  output int                         pending_o
);
  import tzps_pkg::*;

  typedef struct packed {
    logic [31:0] face;
    logic        crossed;
    logic [5:0][31:0] ends;  // a_x a_y a_z b_x b_y b_z, index 0 = a_x
  } segment_t;

  segment_t segment_q[$];
  logic [31:0] plane_z;

  assign pending_o = segment_q.size();

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    fail_count_o++;
  endtask

  // truncated fraction n/s with FB bits, one when n >= s or s is zero
  function automatic logic [63:0] edge_fraction(input logic [63:0] n, input logic [63:0] s);
    if (s == 0 || n >= s) return 64'd1 << FB;
    return (n << FB) / s;
  endfunction

  // point from p toward q at fraction t, rounded toward p
  function automatic logic [31:0] edge_point(input logic signed [31:0] p,
                                             input logic signed [31:0] q,
                                             input logic [63:0] t);
    logic signed [33:0] d;
    logic [63:0] off;
    d = 34'(q) - 34'(p);
    off = (t * 64'(d < 0 ? -d : d)) >> FB;
    return d < 0 ? 32'(34'(p) - 34'(off)) : 32'(34'(p) + 34'(off));
  endfunction

  function automatic segment_t slice_triangle(input logic [IN_W-1:0] w);
    segment_t r;
    logic signed [31:0] v[3][3];
    logic [63:0] reach[3];
    logic low[3];
    logic signed [33:0] d;
    int n, r0, r1, r2;
    logic [63:0] ta, tb;
    r = '0;
    r.face = w[31:0];
    n = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) v[i][j] = w[32 + 32*(3*i+j) +: 32];
      d = 34'(v[i][2]) - 34'($signed(plane_z));
      low[i] = d < 0;
      reach[i] = 64'(d < 0 ? -d : d);
      // saturate to the signed coordinate range
      if (low[i] && reach[i] > 64'h8000_0000) reach[i] = 64'h8000_0000;
      if (!low[i] && reach[i] > 64'h7fff_ffff) reach[i] = 64'h7fff_ffff;
      n += low[i];
    end
    if (n == 0 || n == 3) return r;
    if (low[2] == low[0]) begin r0 = 0; r1 = 1; r2 = 2; end
    else if (low[0] == low[1]) begin r0 = 1; r1 = 2; r2 = 0; end
    else begin r0 = 2; r1 = 0; r2 = 1; end
    ta = edge_fraction(reach[r0], reach[r0] + reach[r1]);
    tb = edge_fraction(reach[r2], reach[r2] + reach[r1]);
    r.crossed = 1'b1;
    for (int j = 0; j < 3; j++) begin
      r.ends[j]   = edge_point(v[r0][j], v[r1][j], ta);
      r.ends[3+j] = edge_point(v[r2][j], v[r1][j], tb);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    segment_t want;
    if (!rst_ni) begin
      plane_z <= '0;
      segment_q.delete();
      fail_count_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == ADDR_Z_LEVEL)
        plane_z <= pwdata_i;
      if (s_tvalid_i && s_tready_i) segment_q = {segment_q, slice_triangle(s_tdata_i)};
      if (m_tvalid_i && m_tready_i) begin
        if (segment_q.size() == 0) begin
          report_mismatch("segment word with none expected, face", m_tdata_i[31:0],
                          32'h0);
        end else begin
          want = segment_q.pop_front();
          if (m_tdata_i[31:0] !== want.face)
            report_mismatch("face_out", m_tdata_i[31:0], want.face);
          if (m_tuser_i !== want.crossed)
            report_mismatch("crossed", 32'(m_tuser_i), 32'(want.crossed));
          for (int j = 0; j < 6; j++)
            if (m_tdata_i[32 + 32*j +: 32] !== want.ends[j])
              report_mismatch($sformatf("segment end %0d", j),
                              m_tdata_i[32 + 32*j +: 32], want.ends[j]);
        end
      end
    end
  end
endmodule

[dv/triangle_z_plane_slice_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_z_plane_slice_unit_tb
// drives triangles and plane heights into the slice unit with random idling
// and a long output hold-off; the checker predicts and compares each word
// ----------------------------------------------------------------------------
module triangle_z_plane_slice_unit_tb;
  import tzps_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic [IN_W-1:0] s_tdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [OUT_W-1:0] m_tdata;
  logic m_tuser, m_tvalid;
  logic m_tready = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fail_count, pending;
  int idle_cycles;
  bit sink_free = 1'b0;   // last part of the run: receiver never stalls
  bit hold_sink = 1'b0;   // request for a long output hold-off

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  triangle_z_plane_slice_unit u_top (
    .clk_i, .rst_ni,
    .s_axis_tdata_i(s_tdata), .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready),
    .m_axis_tdata_o(m_tdata), .m_axis_tuser_o(m_tuser), .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .prdata_o(prdata), .pready_o(pready)
  );

  triangle_z_plane_slice_checker u_checker (
    .clk_i, .rst_ni,
    .s_tdata_i(s_tdata), .s_tvalid_i(s_tvalid), .s_tready_i(s_tready),
    .m_tdata_i(m_tdata), .m_tuser_i(m_tuser), .m_tvalid_i(m_tvalid),
    .m_tready_i(m_tready),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: random stall bursts, or a long hold-off on request
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_sink) begin
        m_tready <= 1'b0;
        repeat (200) @(posedge clk_i);
        hold_sink = 1'b0;
      end else if (!sink_free && $urandom_range(3) == 0) begin
        n = $urandom_range(1, 18);
        m_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_plane(input logic [31:0] z);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_Z_LEVEL; pwdata <= z;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // wait for every expected segment, then idle so the pipe settles
  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (NSTG + 4) @(posedge clk_i);
  endtask

  // offer one triangle, after a random gap if gaps is set, and hold it until accepted
  task automatic send_triangle(input logic [IN_W-1:0] w, input bit gaps);
    int n;
    if (gaps && $urandom_range(4) == 0) begin
      n = $urandom_range(1, 18);
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    s_tdata <= w;
    s_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  task automatic stop_sending();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(0, 64)) - 32);
      default: return $urandom;
    endcase
  endfunction

  // random triangle; mostly with z values near the plane, sometimes anywhere
  function automatic logic [IN_W-1:0] rnd_triangle(input logic [31:0] z);
    logic [IN_W-1:0] w;
    logic signed [63:0] zz;
    w[31:0] = $urandom;
    for (int i = 0; i < 9; i++) w[32 + 32*i +: 32] = rnd_coord();
    if ($urandom_range(4) != 0) begin
      for (int i = 0; i < 3; i++) begin
        case ($urandom_range(3))
          0: zz = 64'($signed(z));
          1: zz = 64'($signed(z)) - $urandom_range(1, 1000);
          2: zz = 64'($signed(z)) + $urandom_range(1, 1000);
          default: zz = 64'($signed(32'($urandom)));
        endcase
        if (zz > 64'sd2147483647) zz = 64'sd2147483647;
        if (zz < -64'sd2147483648) zz = -64'sd2147483648;
        w[32 + 32*(3*i+2) +: 32] = 32'(zz);
      end
    end
    return w;
  endfunction

  function automatic logic [IN_W-1:0] make_triangle(input logic [31:0] face,
      input logic [31:0] x0, y0, z0, x1, y1, z1, x2, y2, z2);
    return {z2, y2, x2, z1, y1, x1, z0, y0, x0, face};
  endfunction

  initial begin
    logic [31:0] plane;
    logic [31:0] levels[6];
    levels = '{32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000, 32'hffff_8000, 32'h0};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset plane height of zero
    send_triangle(make_triangle(32'h0, 1, 2, -5, 3, 4, 5, 6, 7, -5), 0);  // middle odd
    send_triangle(make_triangle(32'hffff_ffff, 1, 2, 5, 3, 4, -5, 6, 7, -5), 0);
    send_triangle(make_triangle(32'h1, 1, 2, -5, 3, 4, -5, 6, 7, 5), 0);
    send_triangle(make_triangle(32'h2, 1, 2, 5, 3, 4, 5, 6, 7, 5), 0);  // all above
    send_triangle(make_triangle(32'h3, 1, 2, -5, 3, 4, -5, 6, 7, -5), 0);  // all below
    send_triangle(make_triangle(32'h4, 1, 2, 0, 3, 4, -1, 6, 7, 0), 0);  // two vertices on plane
    send_triangle(make_triangle(32'h5, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
        32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
        32'h8000_0000), 0);
    send_triangle(make_triangle(32'h6, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
        32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff,
        32'h0), 0);
    stop_sending();
    drain();
    write_plane(32'h8000_0000);  // nothing is below the lowest plane
    send_triangle(make_triangle(32'h7, 1, 1, 32'h8000_0000, 2, 2, 0, 3, 3,
        32'h7fff_ffff), 0);
    stop_sending();
    drain();
    write_plane(32'h7fff_ffff);  // saturated distances
    send_triangle(make_triangle(32'h8, 1, 1, 32'h8000_0000, 2, 2, 32'h7fff_ffff, 3, 3,
        32'h7fff_ffff), 0);
    send_triangle(make_triangle(32'h9, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
        32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 0, 0, 32'h8000_0000), 0);
    stop_sending();
    drain();

    // random phases over several plane heights
    for (int ph = 0; ph < 6; ph++) begin
      plane = (ph == 5) ? $urandom : levels[ph];
      write_plane(plane);
      if (ph == 2) hold_sink = 1'b1;  // fill the pipe and stall the input
      if (ph == 5) sink_free = 1'b1;
      for (int k = 0; k < 150; k++) begin
        send_triangle(rnd_triangle(plane), ph != 5);
        if (ph == 3 && k == 75) begin  // pause until the pipe is empty
          stop_sending();
          while (pending != 0) @(posedge clk_i);
        end
      end
      stop_sending();
      drain();
    end

    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

[sim.f]
hw/rtl/tzps_pkg.sv
hw/rtl/triangle_z_plane_slice_unit.sv
dv/triangle_z_plane_slice_checker.sv
dv/triangle_z_plane_slice_unit_tb.sv
